@@ sv/ipfl_pkg.sv @@
// ============================================================================
// ipfl_pkg
// Shared widths, codes and controller/datapath types for the ID pool
// free-list allocator.
// ============================================================================
package ipfl_pkg;

  localparam int ID_W       = 10;
  localparam int CFG_W      = 11;
  localparam int STATUS_W   = 2;
  localparam int POOL_SIZE  = 1024;

  localparam logic [CFG_W-1:0] LIMIT_RESET = 11'd1024;

  localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_RELEASE = 2'd2;

  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_LINK
  } ctrl_state_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // request transaction taken this cycle
    logic link_load;  // link read data is valid, load new head
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_busy;   // result register full and not drained this cycle
    logic pop_multi;  // presented request pops a list holding two or more IDs
  } dp_status_t;

endpackage

@@ sv/ipfl_if.sv @@
// ============================================================================
// ipfl interfaces
// Request, response and configuration channels, valid/ready handshake.
// ============================================================================
interface ipfl_req_if import ipfl_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            mode;
  logic [ID_W-1:0] release_id;

  modport source (output valid, output mode, output release_id, input ready);
  modport sink   (input valid, input mode, input release_id, output ready);
endinterface

interface ipfl_rsp_if import ipfl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ID_W-1:0]     granted_id;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output granted_id, output status, input ready);
  modport sink   (input valid, input granted_id, input status, output ready);
endinterface

interface ipfl_cfg_if import ipfl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] id_limit;

  modport source (output valid, output id_limit, input ready);
  modport sink   (input valid, input id_limit, output ready);
endinterface

@@ sv/ipfl_ctrl.sv @@
// ============================================================================
// ipfl_ctrl
// Controller: takes request transactions and sequences the link read.
// ============================================================================
module ipfl_ctrl import ipfl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        accept;

  assign accept = req_valid_i && req_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && status_i.pop_multi) state_d = ST_LINK;
      end
      ST_LINK: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready_o     = 1'b0;
    cmd_o.link_load = 1'b0;
    unique case (state_q)
      ST_IDLE: req_ready_o     = !status_i.out_busy;
      ST_LINK: cmd_o.link_load = 1'b1;
      default: ;
    endcase
    cmd_o.accept = req_valid_i && req_ready_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ sv/ipfl_datapath.sv @@
// ============================================================================
// ipfl_datapath
// Pool state, link memory, limit register and result register.
// ============================================================================
module ipfl_datapath import ipfl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                mode_i,
  input  logic [ID_W-1:0]     release_id_i,
  input  logic                cfg_we_i,
  input  logic [CFG_W-1:0]    cfg_limit_i,
  input  dp_cmd_t             cmd_i,
  output dp_status_t          status_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [ID_W-1:0]     granted_id_o,
  output logic [STATUS_W-1:0] status_code_o
);

  localparam int CNT_W  = $clog2(POOL_SIZE + 1);
  localparam int ADDR_W = $clog2(POOL_SIZE);
  localparam int CMP_A  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int CMP_W  = (CMP_A > ID_W) ? CMP_A : ID_W;

  logic [CFG_W-1:0]    limit_q;
  logic [CNT_W-1:0]    hw_q, hw_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [ID_W-1:0]     head_q, head_d;
  logic [ID_W-1:0]     tail_q, tail_d;
  logic                out_valid_q, out_valid_d;
  logic [ID_W-1:0]     granted_q, granted_d;
  logic [STATUS_W-1:0] code_q, code_d;

  logic [ID_W-1:0]     link_mem [POOL_SIZE];
  logic [ID_W-1:0]     link_rdata_q;
  logic                mem_we, mem_re;
  logic [ADDR_W-1:0]   mem_addr;

  logic [CMP_W-1:0] hw_x, count_x, rid_x, limit_x, pool_x, limit_eff;
  logic             empty, multi;

  assign hw_x      = CMP_W'(hw_q);
  assign count_x   = CMP_W'(count_q);
  assign rid_x     = CMP_W'(release_id_i);
  assign limit_x   = CMP_W'(limit_q);
  assign pool_x    = CMP_W'(POOL_SIZE);
  assign limit_eff = (limit_x > pool_x) ? pool_x : limit_x;
  assign empty     = (count_q == '0);
  assign multi     = (count_q > CNT_W'(1));

  assign status_o.pop_multi = (mode_i == MODE_ALLOC) && multi;
  assign status_o.out_busy  = out_valid_q && !out_ready_i;

  always_comb begin
    hw_d      = hw_q;
    count_d   = count_q;
    head_d    = head_q;
    tail_d    = tail_q;
    granted_d = granted_q;
    code_d    = code_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = ADDR_W'(head_q);

    if (cmd_i.link_load) head_d = link_rdata_q;

    if (cmd_i.accept) begin
      granted_d = '0;
      code_d    = STATUS_OK;
      if (mode_i == MODE_ALLOC) begin
        if (empty) begin
          if (hw_x >= limit_eff) begin
            code_d = STATUS_EXHAUSTED;
          end else begin
            granted_d = ID_W'(hw_q);
            hw_d      = hw_q + CNT_W'(1);
          end
        end else begin
          granted_d = head_q;
          count_d   = count_q - CNT_W'(1);
          if (multi) begin
            mem_re = 1'b1;  // successor link read, reloaded into the head in ST_LINK
          end else begin
            head_d = '0;
            tail_d = '0;
          end
        end
      end else begin
        if (rid_x >= hw_x || count_x >= hw_x) begin
          code_d = STATUS_BAD_RELEASE;
        end else begin
          if (empty) begin
            head_d = release_id_i;
          end else begin
            mem_we   = 1'b1;
            mem_addr = ADDR_W'(tail_q);
          end
          tail_d  = release_id_i;
          count_d = count_q + CNT_W'(1);
        end
      end
    end

    out_valid_d = cmd_i.accept || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) link_mem[mem_addr] <= release_id_i;
    if (mem_re) link_rdata_q <= link_mem[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= LIMIT_RESET;
      hw_q        <= '0;
      count_q     <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) limit_q <= cfg_limit_i;
      hw_q        <= hw_d;
      count_q     <= count_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    granted_q <= granted_d;
    code_q    <= code_d;
  end

  assign out_valid_o   = out_valid_q;
  assign granted_id_o  = granted_q;
  assign status_code_o = code_q;

endmodule

@@ sv/id_pool_free_list_allocator.sv @@
// ============================================================================
// id_pool_free_list_allocator
// Hands out and takes back object IDs: FIFO free list plus high-water mark.
// ============================================================================
// Each request transaction (allocate or release) yields exactly one response
// transaction. Allocate pops the free-list head; with an empty list it hands
// out the high-water mark, or answers exhausted once the mark reaches
// min(id_limit, POOL_SIZE). Release appends to the list tail; an ID at or
// above the mark, or a release while the list already holds every issued
// ID, answers invalid release and changes nothing. Timing: an allocate that
// pops a list holding two or more IDs holds off the next request while
// the controller sits in ST_LINK, because the successor link comes from the
// single-port link memory with a registered read. Responses sit in an
// output register, so the next request is taken in the cycle the pending
// response is drained. The link memory needs no clearing pass after reset.
// Write id_limit only while idle.
// ============================================================================
module id_pool_free_list_allocator import ipfl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  ipfl_req_if.sink   req_i,
  ipfl_rsp_if.source rsp_o,
  ipfl_cfg_if.sink   cfg_i
);

  dp_cmd_t    cmd;
  dp_status_t dp_status;

  // limit register is always writable
  assign cfg_i.ready = 1'b1;

  ipfl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .status_i    (dp_status),
    .cmd_o       (cmd)
  );

  ipfl_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mode_i        (req_i.mode),
    .release_id_i  (req_i.release_id),
    .cfg_we_i      (cfg_i.valid),
    .cfg_limit_i   (cfg_i.id_limit),
    .cmd_i         (cmd),
    .status_o      (dp_status),
    .out_ready_i   (rsp_o.ready),
    .out_valid_o   (rsp_o.valid),
    .granted_id_o  (rsp_o.granted_id),
    .status_code_o (rsp_o.status)
  );

  // a multi-entry pop must be followed by the head reload
  a_pop_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.accept && dp_status.pop_multi |=> cmd.link_load)
    else $error("head reload missing after pop");

  // no new request while the head is being reloaded
  a_link_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.link_load |-> !req_i.ready)
    else $error("request taken during head reload");

  // every accepted request produces a pending response
  a_rsp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.accept |=> rsp_o.valid)
    else $error("response missing after request");

endmodule
